### rtl/mvt_pkg.sv
package mvt_pkg;

    // Matrix geometry and fixed-point format.
    localparam int MAX_ORDER = 4;
    localparam int FRAC_BITS = 16;
    localparam int NUM_COMP  = 4;
    localparam int DATA_W    = 32;
    localparam int ORDER_W   = 3;
    localparam int IDX_W     = 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + $clog2(MAX_ORDER);

    // Request codes carried in req_type.
    localparam logic REQ_WRITE     = 1'b0;
    localparam logic REQ_TRANSFORM = 1'b1;

    // Matrix order after reset.
    localparam logic [ORDER_W-1:0] RESET_ORDER = ORDER_W'(4);

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // One input beat.
    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         entry_row;
        logic [IDX_W-1:0]         entry_col;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] tuple_x;
        logic signed [DATA_W-1:0] tuple_y;
        logic signed [DATA_W-1:0] tuple_z;
        logic signed [DATA_W-1:0] tuple_w;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     saturated;
    } out_t;

endpackage

### rtl/mvt_row_sum.sv
module mvt_row_sum (
    input  mvt_pkg::prod_t prod [mvt_pkg::MAX_ORDER],
    output mvt_pkg::word_t value,
    output logic           sat
);
    import mvt_pkg::*;

    localparam int SH_W = SUM_W - FRAC_BITS;

    logic signed [SUM_W-1:0] acc;
    logic signed [SH_W-1:0]  shifted;
    logic                    all_ones;
    logic                    all_zeros;

    // Exact sum of the products of one row.
    always_comb
    begin
        acc = '0;
        for (int j = 0; j < MAX_ORDER; j++)
        begin
            acc = acc + SUM_W'(prod[j]);
        end
    end

    // Floor shift back to Q16.16: dropping the low bits of a two's
    // complement value rounds toward minus infinity.
    assign shifted = acc[SUM_W-1:FRAC_BITS];

    // The value fits when every bit above the result sign matches it.
    assign all_ones  = &shifted[SH_W-1:DATA_W-1];
    assign all_zeros = ~|shifted[SH_W-1:DATA_W-1];

    always_comb
    begin
        sat = !(all_ones || all_zeros);
        if (all_ones || all_zeros)
        begin
            value = shifted[DATA_W-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

### rtl/matrix_vector_transform.sv
// Matrix-vector transform.
// The block holds a square matrix of signed Q16.16 entries (up to 4x4) and
// multiplies four-component tuples by the top-left corner of the active
// order. The input channel (in_valid, in_stall, in_data) carries two kinds
// of beat: a write beat loads one matrix entry and yields no result; a
// transform beat yields exactly one result beat on the output channel
// (out_valid, out_stall, out_data). Results leave in input order.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the
// matrix order; cfg_ready is always high. The user must change the order only
// while no transform is in flight; the block itself does not enforce it.
// A transform beat passes through the input register, the product register
// and the result register before it is shown on out_valid.
// Throughput: one beat per cycle while the receiver does not stall; the sixteen
// 32x32 multipliers work in parallel and a full register stage sits after them.
// Reset clears the matrix to zero, sets the order to 4 and empties the
// pipeline. When the receiver stalls, the result register holds its beat
// and the stages behind it keep filling; in_stall rises only once every
// stage is occupied.
module matrix_vector_transform (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mvt_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mvt_pkg::out_t                 out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mvt_pkg::ORDER_W-1:0]   cfg_data
);
    import mvt_pkg::*;

    logic               s0_valid_reg;
    in_t                s0_data_reg;
    logic               s1_valid_reg;
    prod_t              prod_reg  [MAX_ORDER][MAX_ORDER];
    prod_t              prod_next [MAX_ORDER][MAX_ORDER];
    logic               out_valid_reg;
    out_t               out_data_reg;
    out_t               out_data_next;
    word_t              matrix_reg [MAX_ORDER][MAX_ORDER];
    logic [ORDER_W-1:0] order_reg;
    logic [ORDER_W-1:0] order_eff;
    word_t              tup [NUM_COMP];
    word_t              row_value [MAX_ORDER];
    logic [MAX_ORDER-1:0] row_sat;
    word_t              res [NUM_COMP];
    logic               out_ready;
    logic               s1_ready;
    logic               s0_is_write;
    logic               s0_advance;
    logic               s0_ready;
    logic               entry_in_range;

    // Pipeline flow control: a write beat retires from the input register
    // on its own, a transform beat needs room in the product stage.
    assign out_ready   = !out_valid_reg || !out_stall;
    assign s1_ready    = !s1_valid_reg || out_ready;
    assign s0_is_write = (s0_data_reg.req_type == REQ_WRITE);
    assign s0_advance  = s0_valid_reg && (s0_is_write || s1_ready);
    assign s0_ready    = !s0_valid_reg || s0_advance;
    assign in_stall    = !s0_ready;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_data_reg <= in_data;
        end
    end

    // Matrix order register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= RESET_ORDER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            order_reg <= cfg_data;
        end
    end

    assign order_eff = (order_reg > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_reg;

    // Matrix store. Entries change as a write beat leaves the input
    // register, the same place where transform beats read them, so every
    // transform sees exactly the writes that came before it.
    assign entry_in_range = ({1'b0, s0_data_reg.entry_row} < (IDX_W + 1)'(MAX_ORDER))
                         && ({1'b0, s0_data_reg.entry_col} < (IDX_W + 1)'(MAX_ORDER));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                for (int j = 0; j < MAX_ORDER; j++)
                begin
                    matrix_reg[i][j] <= '0;
                end
            end
        end
        else if (s0_advance && s0_is_write && entry_in_range)
        begin
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                for (int j = 0; j < MAX_ORDER; j++)
                begin
                    if ((s0_data_reg.entry_row == IDX_W'(i))
                        && (s0_data_reg.entry_col == IDX_W'(j)))
                    begin
                        matrix_reg[i][j] <= s0_data_reg.entry_value;
                    end
                end
            end
        end
    end

    // Tuple components as an array.
    assign tup[0] = s0_data_reg.tuple_x;
    assign tup[1] = s0_data_reg.tuple_y;
    assign tup[2] = s0_data_reg.tuple_z;
    assign tup[3] = s0_data_reg.tuple_w;

    // Products; entries outside the active order contribute zero.
    always_comb
    begin
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            for (int j = 0; j < MAX_ORDER; j++)
            begin
                if ((ORDER_W'(i) < order_eff) && (ORDER_W'(j) < order_eff))
                begin
                    prod_next[i][j] = matrix_reg[i][j] * tup[j];
                end
                else
                begin
                    prod_next[i][j] = '0;
                end
            end
        end
    end

    // Product register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_advance && !s0_is_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_advance && !s0_is_write)
        begin
            prod_reg <= prod_next;
        end
    end

    // Row sums with shift and saturation.
    for (genvar r = 0; r < MAX_ORDER; r++)
    begin : g_row
        mvt_row_sum u_row_sum (
            .prod  (prod_reg[r]),
            .value (row_value[r]),
            .sat   (row_sat[r])
        );
    end

    // Components beyond the matrix size are zero.
    for (genvar k = 0; k < NUM_COMP; k++)
    begin : g_comp
        if (k < MAX_ORDER)
        begin : g_used
            assign res[k] = row_value[k];
        end
        else
        begin : g_unused
            assign res[k] = '0;
        end
    end

    always_comb
    begin
        out_data_next.out_x     = res[0];
        out_data_next.out_y     = res[1];
        out_data_next.out_z     = res[2];
        out_data_next.out_w     = res[3];
        out_data_next.saturated = |row_sat;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

### rtl/mvt_checker.sv
module mvt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input mvt_pkg::in_t                in_data,
    input logic                        out_valid,
    input logic                        out_stall,
    input mvt_pkg::out_t               out_data
);
    import mvt_pkg::*;

    logic xf_accept;
    logic [DATA_W-1:0] max_pos;
    logic [DATA_W-1:0] max_neg;

    assign xf_accept = in_valid && !in_stall && (in_data.req_type == REQ_TRANSFORM);
    assign max_pos   = {1'b0, {(DATA_W-1){1'b1}}};
    assign max_neg   = {1'b1, {(DATA_W-1){1'b0}}};

    // A stalled result beat stays offered.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // Unstalled, a transform crosses the input, product and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        xf_accept ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("transform result missing after pipeline latency");

    // A saturated result carries at least one clamped component.
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            (out_data.out_x == max_pos) || (out_data.out_x == max_neg)
         || (out_data.out_y == max_pos) || (out_data.out_y == max_neg)
         || (out_data.out_z == max_pos) || (out_data.out_z == max_neg)
         || (out_data.out_w == max_pos) || (out_data.out_w == max_neg))
        else $error("saturated flag without a clamped component");

endmodule

bind matrix_vector_transform mvt_checker u_mvt_checker (.*);

### tb/tb_matrix_vector_transform.sv
module tb_matrix_vector_transform;

    import mvt_pkg::*;

    // Handy Q16.16 values for the directed beats.
    localparam word_t MAXW    = 32'sh7FFF_FFFF;
    localparam word_t MINW    = 32'sh8000_0000;
    localparam word_t ONE     = 32'sh0001_0000;
    localparam word_t NEG_ONE = 32'shFFFF_0000;

    // Clamp bounds at the width of the dot-product accumulator.
    localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - 1;

    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_BEATS   = 50;
    localparam int SETTLE_CYCLES = 8;

    // One row of the directed plan: either an order change or an input beat.
    typedef struct packed {
        bit                 is_order;
        logic [ORDER_W-1:0] order_val;
        in_t                beat;
        bit                 typed;
        out_t               want;
    } step_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_t                in_data;
    logic               out_valid;
    logic               out_stall;
    out_t               out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [ORDER_W-1:0] cfg_data;

    // Shadow copy of the block state and the results still owed by it.
    word_t              coeff_q [MAX_ORDER][MAX_ORDER];
    logic [ORDER_W-1:0] order_q;
    out_t               pending_vectors [$];
    step_t              plan [$];

    bit       tx_quiet;
    bit       rx_quiet;
    int       errors;
    int       n_writes;
    int       n_xforms;
    int       n_clamped;
    bit [7:0] orders_seen;

    matrix_vector_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Multiply the tuple by the active corner of the shadow matrix.
    // Each row sum is exact, floored by the fraction width, then clamped.
    function automatic out_t transform_tuple(in_t beat);
        word_t                    comp [NUM_COMP];
        word_t                    res [NUM_COMP];
        logic signed [SUM_W-1:0]  acc;
        logic signed [SUM_W-1:0]  lhs;
        logic signed [SUM_W-1:0]  rhs;
        int                       n;
        bit                       clamped;
        out_t                     r;
        comp[0] = beat.tuple_x;
        comp[1] = beat.tuple_y;
        comp[2] = beat.tuple_z;
        comp[3] = beat.tuple_w;
        n = (order_q > MAX_ORDER) ? MAX_ORDER : int'(order_q);
        clamped = 1'b0;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            res[i] = '0;
            if (i < n)
            begin
                acc = '0;
                for (int j = 0; j < n; j++)
                begin
                    lhs = coeff_q[i][j];
                    rhs = comp[j];
                    acc += lhs * rhs;
                end
                acc = acc >>> FRAC_BITS;
                if (acc > ACC_HI)
                begin
                    acc = ACC_HI;
                    clamped = 1'b1;
                end
                else if (acc < ACC_LO)
                begin
                    acc = ACC_LO;
                    clamped = 1'b1;
                end
                res[i] = word_t'(acc);
            end
        end
        r.out_x     = res[0];
        r.out_y     = res[1];
        r.out_z     = res[2];
        r.out_w     = res[3];
        r.saturated = clamped;
        return r;
    endfunction

    function automatic out_t mk_out(word_t x, word_t y, word_t z, word_t w, bit sat);
        out_t r;
        r.out_x     = x;
        r.out_y     = y;
        r.out_z     = z;
        r.out_w     = w;
        r.saturated = sat;
        return r;
    endfunction

    // Random Q16.16 word: full range, small magnitudes, an extreme, or one, minus one or zero.
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return word_t'($urandom);
            4, 5, 6:    return word_t'($urandom_range(0, 32'h0008_0000)) - word_t'(32'h0004_0000);
            7:          return MAXW;
            8:          return MINW;
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return ONE;
                    1:       return NEG_ONE;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic in_t random_beat();
        in_t b;
        b.req_type    = ($urandom_range(0, 9) < 4) ? REQ_WRITE : REQ_TRANSFORM;
        b.entry_row   = IDX_W'($urandom_range(0, 3));
        b.entry_col   = IDX_W'($urandom_range(0, 3));
        b.entry_value = pick_word();
        b.tuple_x     = pick_word();
        b.tuple_y     = pick_word();
        b.tuple_z     = pick_word();
        b.tuple_w     = pick_word();
        return b;
    endfunction

    // Directed plan builders. Fields that the beat kind ignores get noise.
    function automatic void plan_write(int r, int c, word_t v);
        step_t s;
        s = '0;
        s.beat.req_type    = REQ_WRITE;
        s.beat.entry_row   = IDX_W'(r);
        s.beat.entry_col   = IDX_W'(c);
        s.beat.entry_value = v;
        s.beat.tuple_x     = word_t'($urandom);
        s.beat.tuple_y     = word_t'($urandom);
        s.beat.tuple_z     = word_t'($urandom);
        s.beat.tuple_w     = word_t'($urandom);
        plan.push_back(s);
    endfunction

    function automatic void plan_xform(word_t x, word_t y, word_t z, word_t w,
                                       bit typed = 1'b0, out_t want = '0);
        step_t s;
        s = '0;
        s.beat.req_type    = REQ_TRANSFORM;
        s.beat.entry_row   = IDX_W'($urandom_range(0, 3));
        s.beat.entry_col   = IDX_W'($urandom_range(0, 3));
        s.beat.entry_value = word_t'($urandom);
        s.beat.tuple_x     = x;
        s.beat.tuple_y     = y;
        s.beat.tuple_z     = z;
        s.beat.tuple_w     = w;
        s.typed            = typed;
        s.want             = want;
        plan.push_back(s);
    endfunction

    function automatic void plan_order(int v);
        step_t s;
        s = '0;
        s.is_order  = 1'b1;
        s.order_val = ORDER_W'(v);
        plan.push_back(s);
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // Present one input beat after a random gap (none while tx_quiet) and hold it until taken.
    // The shadow state is updated at the accepting edge.
    task automatic send_beat(input in_t beat, input bit typed, input out_t want);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        if (beat.req_type == REQ_WRITE)
        begin
            coeff_q[beat.entry_row][beat.entry_col] = beat.entry_value;
            n_writes++;
        end
        else
        begin
            pending_vectors.push_back(typed ? want : transform_tuple(beat));
            n_xforms++;
        end
    endtask

    // Let every owed result come out, then give trailing write beats time to land.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_vectors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_order(input logic [ORDER_W-1:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        order_q = value;
        orders_seen[value] = 1'b1;
    endtask

    // Result side: stall for a random number of cycles (none while rx_quiet) before each beat.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = rx_quiet ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare every accepted result beat with the oldest owed vector.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_vectors.size() == 0)
            begin
                $error("result beat with nothing owed: %h", out_data);
                errors++;
            end
            else
            begin
                want = pending_vectors.pop_front();
                check_field("out_x", want.out_x, out_data.out_x);
                check_field("out_y", want.out_y, out_data.out_y);
                check_field("out_z", want.out_z, out_data.out_z);
                check_field("out_w", want.out_w, out_data.out_w);
                check_field("saturated", DATA_W'(want.saturated), DATA_W'(out_data.saturated));
                if (out_data.saturated === 1'b1)
                    n_clamped++;
            end
        end
    end

    // Main sequence: reset, directed plan, then random phases over all orders.
    initial
    begin
        logic [ORDER_W-1:0] fixed_orders [8];
        logic [ORDER_W-1:0] next_order;
        fixed_orders = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        errors      = 0;
        n_writes    = 0;
        n_xforms    = 0;
        n_clamped   = 0;
        orders_seen = 8'b0001_0000;
        order_q     = RESET_ORDER;
        for (int i = 0; i < MAX_ORDER; i++)
            for (int j = 0; j < MAX_ORDER; j++)
                coeff_q[i][j] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cleared matrix gives zero for any tuple.
        plan_xform(MAXW, MINW, MAXW, MINW, 1'b1, mk_out(0, 0, 0, 0, 1'b0));
        // Diagonal of extremes, one and minus one.
        plan_write(0, 0, MAXW);
        plan_write(1, 1, MINW);
        plan_write(2, 2, ONE);
        plan_write(3, 3, NEG_ONE);
        plan_xform(MAXW, MINW, 32'sh1234_5678, 32'sh0002_0000, 1'b1,
                   mk_out(MAXW, MAXW, 32'sh1234_5678, 32'shFFFE_0000, 1'b1));
        plan_xform(MINW, 0, 0, 0, 1'b1, mk_out(MINW, 0, 0, 0, 1'b1));
        plan_xform(0, 0, 0, 0, 1'b1, mk_out(0, 0, 0, 0, 1'b0));
        // Floor rounding of a tiny negative product.
        plan_write(0, 0, 0);
        plan_write(0, 1, 1);
        plan_xform(32'sh0003_0000, -1, 32'sh0000_8000, MAXW);
        // A full row of maximum entries against a maximum tuple.
        plan_write(3, 0, MAXW);
        plan_write(3, 1, MAXW);
        plan_write(3, 2, MAXW);
        plan_write(3, 3, MAXW);
        plan_xform(MAXW, MAXW, MAXW, MAXW);
        plan_write(2, 3, 32'sh9ABC_DEF1);
        plan_write(1, 2, 32'sh0000_8000);
        plan_xform(32'sh7FFF_0000, 32'shC000_1234, 32'sh0101_0101, MINW);
        // Order one, order zero, an order above the maximum, and a middle one.
        plan_order(1);
        plan_xform(32'sh0004_0000, MAXW, MAXW, MAXW);
        plan_order(0);
        plan_xform(MAXW, MAXW, MAXW, MAXW, 1'b1, mk_out(0, 0, 0, 0, 1'b0));
        plan_order(7);
        plan_xform(MINW, MINW, ONE, NEG_ONE);
        plan_order(2);
        plan_xform(32'sh0002_8000, 32'shFFFD_0000, MAXW, MINW);

        for (int k = 0; k < plan.size(); k++)
        begin
            if (plan[k].is_order)
                set_order(plan[k].order_val);
            else
                send_beat(plan[k].beat, plan[k].typed, plan[k].want);
        end

        // Random phases, each under its own order; idling changes every 25 beats.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            next_order = (p < 8) ? fixed_orders[p] : ORDER_W'($urandom_range(0, 7));
            set_order(next_order);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                if (k % 25 == 0)
                begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                send_beat(random_beat(), 1'b0, '0);
            end
        end

        drain_pipeline();
        $display("Run covered %0d matrix writes and %0d transforms; %0d results clamped.",
                 n_writes, n_xforms, n_clamped);
        $display("Matrix order values exercised (bit per value 7..0): %b", orders_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/mvt_pkg.sv
rtl/mvt_row_sum.sv
rtl/matrix_vector_transform.sv
rtl/mvt_checker.sv
tb/tb_matrix_vector_transform.sv
